FILE: rtl/dfs_pkg.sv
// ---------------------------------------------------------------------------
// dfs_pkg
// shared sizes, codes and types of the depth-first order iterator
// ---------------------------------------------------------------------------
package dfs_pkg;

    localparam int MAX_VERTICES = 256;
    localparam int MAX_EDGES    = 1024;

    localparam int ID_W   = 32;
    localparam int FUNC_W = 2;
    localparam int SLOT_W = $clog2(MAX_VERTICES);
    localparam int VCNT_W = SLOT_W + 1;
    localparam int EDGE_W = $clog2(MAX_EDGES);
    localparam int ECNT_W = EDGE_W + 1;

    typedef enum logic [FUNC_W-1:0] {
        FN_ADD_VERTEX   = 2'd0,
        FN_ADD_NEIGHBOR = 2'd1,
        FN_RESTART      = 2'd2,
        FN_ADVANCE      = 2'd3
    } func_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MIN,
        S_SCAN,
        S_POP,
        S_VISIT,
        S_EDGE,
        S_RDID,
        S_IDW,
        S_RESP
    } state_t;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [ECNT_W-1:0] start;
    } vtx_word_t;

    typedef struct packed {
        logic [ID_W-1:0] current_id;
        logic            at_end;
        logic            load_full;
    } res_t;

endpackage

FILE: rtl/dfs_order_iterator.sv
// ---------------------------------------------------------------------------
// dfs_order_iterator
// loads a graph and steps through it in stack-based depth-first order
//
//   channel  handshake           payload
//   in       in_valid/in_stall   func, vertex_id, neighbor_slot
//   out      out_valid/out_stall current_id, at_end, load_full
//
// loads pass through the result state to the output register; reset traversal
// reads one id per cycle for the lowest id, and advance pops the stack or scans
// the slots for an unvisited one when the stack is empty; both then read one
// neighbor per cycle and push the unvisited ones;
// visit marks are cleared during the lowest-id pass and each added vertex
// clears its own, so there is no clearing pass after reset;
// one word is held in the output register while the next one is worked on
// ---------------------------------------------------------------------------
module dfs_order_iterator
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [dfs_pkg::FUNC_W-1:0]  func,
    input  logic [dfs_pkg::ID_W-1:0]    vertex_id,
    input  logic [dfs_pkg::SLOT_W-1:0]  neighbor_slot,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [dfs_pkg::ID_W-1:0]    current_id,
    output logic                        at_end,
    output logic                        load_full
);
    import dfs_pkg::*;

    logic busy;
    logic res_valid;
    logic res_take;
    res_t res;
    res_t out_reg;
    logic out_valid_reg, out_valid_next;

    dfs_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (in_valid),
        .req_func  (func),
        .req_id    (vertex_id),
        .req_nbr   (neighbor_slot),
        .busy      (busy),
        .res_valid (res_valid),
        .res       (res),
        .res_take  (res_take)
    );

    assign in_stall = busy;
    assign res_take = res_valid && (!out_valid_reg || !out_stall);

    always_comb
    begin
        if (res_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_stall)
        begin
            out_valid_next = out_valid_reg;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_reg <= res;
        end
    end

    assign out_valid  = out_valid_reg;
    assign current_id = out_reg.current_id;
    assign at_end     = out_reg.at_end;
    assign load_full  = out_reg.load_full;

endmodule

FILE: rtl/dfs_core.sv
// ---------------------------------------------------------------------------
// dfs_core
// graph tables, search stack and the sequencer that loads and walks them
// ---------------------------------------------------------------------------
module dfs_core
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    input  logic [dfs_pkg::FUNC_W-1:0]  req_func,
    input  logic [dfs_pkg::ID_W-1:0]    req_id,
    input  logic [dfs_pkg::SLOT_W-1:0]  req_nbr,
    output logic                        busy,
    output logic                        res_valid,
    output dfs_pkg::res_t               res,
    input  logic                        res_take
);
    import dfs_pkg::*;

    // memories
    vtx_word_t         vtx_mem  [MAX_VERTICES];
    logic [ECNT_W-1:0] cnt_mem  [MAX_VERTICES];
    logic [SLOT_W-1:0] nb_mem   [MAX_EDGES];
    logic [SLOT_W-1:0] stk_mem  [MAX_VERTICES];
    logic              seen_mem [MAX_VERTICES];

    vtx_word_t         vtx_q;
    logic [ECNT_W-1:0] cnt_q;
    logic [SLOT_W-1:0] nb_q;
    logic [SLOT_W-1:0] stk_q;
    logic              seen_q;

    logic              vtx_we, cnt_we, nb_we, stk_we, seen_we;
    logic [SLOT_W-1:0] vtx_wr_addr, cnt_wr_addr, stk_wr_addr, seen_wr_addr;
    logic [EDGE_W-1:0] nb_wr_addr;
    vtx_word_t         vtx_wr_data;
    logic [ECNT_W-1:0] cnt_wr_data;
    logic [SLOT_W-1:0] nb_wr_data, stk_wr_data;
    logic              seen_wr_data;
    logic [SLOT_W-1:0] vtx_rd_addr, cnt_rd_addr, stk_rd_addr, seen_rd_addr;
    logic [EDGE_W-1:0] nb_rd_addr;

    // control state
    state_t                  state_reg, state_next;
    logic [VCNT_W-1:0]       vt_reg, vt_next;
    logic [ECNT_W-1:0]       et_reg, et_next;
    logic [ECNT_W-1:0]       last_cnt_reg, last_cnt_next;
    logic [VCNT_W-1:0]       depth_reg, depth_next;
    logic [SLOT_W-1:0]       cur_reg, cur_next;
    logic                    done_reg, done_next;
    logic [VCNT_W-1:0]       idx_reg, idx_next;
    logic                    pv_reg, pv_next;
    logic                    pv2_reg, pv2_next;
    logic [SLOT_W-1:0]       pidx_reg, pidx_next;
    logic [SLOT_W-1:0]       n2_reg, n2_next;
    logic                    fwd_reg, fwd_next;
    logic [SLOT_W-1:0]       best_reg, best_next;
    logic [ID_W-1:0]         best_id_reg, best_id_next;
    logic [ECNT_W-1:0]       e_reg, e_next;
    logic [ECNT_W:0]         e_end_reg, e_end_next;
    res_t                    res_reg, res_next;

    logic              visit_go;
    logic [SLOT_W-1:0] visit_slot;
    logic              issue;
    logic              push;
    logic [VCNT_W-1:0] depth_m1;
    logic [SLOT_W-1:0] idx_slot;

    function automatic logic [SLOT_W-1:0] depth_slot_fix(input logic [VCNT_W-1:0] total);
        logic [VCNT_W-1:0] last;
        last = total - VCNT_W'(1);
        return last[SLOT_W-1:0];
    endfunction

    assign busy      = (state_reg != S_IDLE);
    assign res_valid = (state_reg == S_RESP);
    assign res       = res_reg;
    assign depth_m1  = depth_reg - VCNT_W'(1);
    assign idx_slot  = idx_reg[SLOT_W-1:0];

    always_ff @(posedge clk)
    begin
        if (vtx_we)
        begin
            vtx_mem[vtx_wr_addr] <= vtx_wr_data;
        end
        if (cnt_we)
        begin
            cnt_mem[cnt_wr_addr] <= cnt_wr_data;
        end
        if (nb_we)
        begin
            nb_mem[nb_wr_addr] <= nb_wr_data;
        end
        if (stk_we)
        begin
            stk_mem[stk_wr_addr] <= stk_wr_data;
        end
        if (seen_we)
        begin
            seen_mem[seen_wr_addr] <= seen_wr_data;
        end
        vtx_q  <= vtx_mem[vtx_rd_addr];
        cnt_q  <= cnt_mem[cnt_rd_addr];
        nb_q   <= nb_mem[nb_rd_addr];
        stk_q  <= stk_mem[stk_rd_addr];
        seen_q <= seen_mem[seen_rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            vt_reg       <= '0;
            et_reg       <= '0;
            last_cnt_reg <= '0;
            depth_reg    <= '0;
            cur_reg      <= '0;
            done_reg     <= 1'b1;
            idx_reg      <= '0;
            pv_reg       <= 1'b0;
            pv2_reg      <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            vt_reg       <= vt_next;
            et_reg       <= et_next;
            last_cnt_reg <= last_cnt_next;
            depth_reg    <= depth_next;
            cur_reg      <= cur_next;
            done_reg     <= done_next;
            idx_reg      <= idx_next;
            pv_reg       <= pv_next;
            pv2_reg      <= pv2_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pidx_reg    <= pidx_next;
        n2_reg      <= n2_next;
        fwd_reg     <= fwd_next;
        best_reg    <= best_next;
        best_id_reg <= best_id_next;
        e_reg       <= e_next;
        e_end_reg   <= e_end_next;
        res_reg     <= res_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        vt_next       = vt_reg;
        et_next       = et_reg;
        last_cnt_next = last_cnt_reg;
        depth_next    = depth_reg;
        cur_next      = cur_reg;
        done_next     = done_reg;
        idx_next      = idx_reg;
        pv_next       = 1'b0;
        pv2_next      = 1'b0;
        pidx_next     = pidx_reg;
        n2_next       = n2_reg;
        fwd_next      = 1'b0;
        best_next     = best_reg;
        best_id_next  = best_id_reg;
        e_next        = e_reg;
        e_end_next    = e_end_reg;
        res_next      = res_reg;
        vtx_we        = 1'b0;
        cnt_we        = 1'b0;
        nb_we         = 1'b0;
        stk_we        = 1'b0;
        seen_we       = 1'b0;
        vtx_wr_addr   = vt_reg[SLOT_W-1:0];
        vtx_wr_data   = '{id: req_id, start: et_reg};
        cnt_wr_addr   = vt_reg[SLOT_W-1:0];
        cnt_wr_data   = '0;
        nb_wr_addr    = et_reg[EDGE_W-1:0];
        nb_wr_data    = req_nbr;
        stk_wr_addr   = depth_reg[SLOT_W-1:0];
        stk_wr_data   = n2_reg;
        seen_wr_addr  = vt_reg[SLOT_W-1:0];
        seen_wr_data  = 1'b0;
        vtx_rd_addr   = idx_slot;
        cnt_rd_addr   = idx_slot;
        nb_rd_addr    = e_reg[EDGE_W-1:0];
        stk_rd_addr   = depth_m1[SLOT_W-1:0];
        seen_rd_addr  = idx_slot;
        visit_go      = 1'b0;
        visit_slot    = stk_q;
        issue         = 1'b0;
        push          = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    res_next   = '0;
                    state_next = S_RESP;
                    unique case (func_t'(req_func))
                        FN_ADD_VERTEX:
                        begin
                            if (vt_reg >= VCNT_W'(MAX_VERTICES))
                            begin
                                res_next.load_full = 1'b1;
                            end
                            else
                            begin
                                // new slot starts unvisited
                                vtx_we        = 1'b1;
                                cnt_we        = 1'b1;
                                seen_we       = 1'b1;
                                vt_next       = vt_reg + VCNT_W'(1);
                                last_cnt_next = '0;
                            end
                        end
                        FN_ADD_NEIGHBOR:
                        begin
                            if (vt_reg != '0)
                            begin
                                if (et_reg >= ECNT_W'(MAX_EDGES))
                                begin
                                    res_next.load_full = 1'b1;
                                end
                                else
                                begin
                                    nb_we         = 1'b1;
                                    cnt_we        = 1'b1;
                                    cnt_wr_addr   = depth_slot_fix(vt_reg);
                                    cnt_wr_data   = last_cnt_reg + ECNT_W'(1);
                                    last_cnt_next = last_cnt_reg + ECNT_W'(1);
                                    et_next       = et_reg + ECNT_W'(1);
                                end
                            end
                        end
                        FN_RESTART:
                        begin
                            depth_next = '0;
                            if (vt_reg == '0)
                            begin
                                cur_next   = '0;
                                done_next  = 1'b1;
                                state_next = S_RDID;
                            end
                            else
                            begin
                                idx_next   = '0;
                                state_next = S_MIN;
                            end
                        end
                        FN_ADVANCE:
                        begin
                            idx_next = '0;
                            if (depth_reg == '0)
                            begin
                                state_next = S_SCAN;
                            end
                            else
                            begin
                                depth_next = depth_m1;
                                state_next = S_POP;
                            end
                        end
                        default:
                        begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end
            S_MIN:
            begin
                // lowest id search, clearing visit marks on the way
                issue     = (idx_reg < vt_reg);
                pv_next   = issue;
                pidx_next = idx_slot;
                if (issue)
                begin
                    idx_next     = idx_reg + VCNT_W'(1);
                    seen_we      = 1'b1;
                    seen_wr_addr = idx_slot;
                    seen_wr_data = 1'b0;
                end
                if (pv_reg)
                begin
                    if ((pidx_reg == '0) || ($signed(vtx_q.id) < $signed(best_id_reg)))
                    begin
                        best_next    = pidx_reg;
                        best_id_next = vtx_q.id;
                    end
                end
                if (!issue && !pv_reg)
                begin
                    visit_go   = 1'b1;
                    visit_slot = best_reg;
                end
            end
            S_SCAN:
            begin
                issue     = (idx_reg < vt_reg);
                pv_next   = issue;
                pidx_next = idx_slot;
                if (issue)
                begin
                    idx_next = idx_reg + VCNT_W'(1);
                end
                if (pv_reg && !seen_q)
                begin
                    visit_go   = 1'b1;
                    visit_slot = pidx_reg;
                end
                else if (!issue && !pv_reg)
                begin
                    done_next  = 1'b1;
                    state_next = S_RDID;
                end
            end
            S_POP:
            begin
                visit_go   = 1'b1;
                visit_slot = stk_q;
            end
            S_VISIT:
            begin
                e_next     = vtx_q.start;
                e_end_next = {1'b0, vtx_q.start} + {1'b0, cnt_q};
                state_next = S_EDGE;
            end
            S_EDGE:
            begin
                // neighbor read, then mark read, then push
                issue   = ({1'b0, e_reg} < e_end_reg) && (e_reg < et_reg);
                pv_next = issue;
                if (issue)
                begin
                    e_next = e_reg + ECNT_W'(1);
                end
                push = pv2_reg && !seen_q && !fwd_reg;
                if (pv_reg && ({1'b0, nb_q} < vt_reg))
                begin
                    seen_rd_addr = nb_q;
                    pv2_next     = 1'b1;
                    n2_next      = nb_q;
                    // mark written this cycle is not yet in the read data
                    fwd_next     = push && (n2_reg == nb_q);
                end
                if (push)
                begin
                    seen_we      = 1'b1;
                    seen_wr_addr = n2_reg;
                    seen_wr_data = 1'b1;
                    if (depth_reg < VCNT_W'(MAX_VERTICES))
                    begin
                        stk_we     = 1'b1;
                        depth_next = depth_reg + VCNT_W'(1);
                    end
                end
                if (!issue && !pv_reg && !pv2_reg)
                begin
                    state_next = S_RDID;
                end
            end
            S_RDID:
            begin
                vtx_rd_addr = cur_reg;
                state_next  = S_IDW;
            end
            S_IDW:
            begin
                res_next.current_id = ({1'b0, cur_reg} < vt_reg) ? vtx_q.id : '0;
                res_next.at_end     = done_reg;
                res_next.load_full  = 1'b0;
                state_next          = S_RESP;
            end
            S_RESP:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (visit_go)
        begin
            cur_next     = visit_slot;
            seen_we      = 1'b1;
            seen_wr_addr = visit_slot;
            seen_wr_data = 1'b1;
            done_next    = 1'b0;
            vtx_rd_addr  = visit_slot;
            cnt_rd_addr  = visit_slot;
            state_next   = S_VISIT;
        end
    end

    a_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (depth_reg <= VCNT_W'(MAX_VERTICES)) && (vt_reg <= VCNT_W'(MAX_VERTICES))
        && (et_reg <= ECNT_W'(MAX_EDGES)))
        else $error("table or stack count beyond capacity");

    a_done_empty: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (depth_reg == '0))
        else $error("walk finished with words left on the stack");

    a_full_load: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_reg.load_full) |-> (!res_reg.at_end && (res_reg.current_id == '0)))
        else $error("dropped load reports traversal data");

    a_take_leaves: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_take) |=> (state_reg == S_IDLE))
        else $error("result taken but sequencer did not return to idle");

endmodule
